FILE: design/per_flow_sequence_tracker_top_defines.svh
// Assertion macros shared by the tracker modules.
`ifndef PER_FLOW_SEQUENCE_TRACKER_TOP_DEFINES_SVH
`define PER_FLOW_SEQUENCE_TRACKER_TOP_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define PFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequence is checked in the cycle after its antecedent.
`define PFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pft_pkg.sv
package pft_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W = 6;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] addr;
  } key_t;

  localparam int unsigned KEY_W = $bits(key_t);

  typedef struct packed {
    logic [63:0] back;
    logic [63:0] gap;
    logic [63:0] recv;
    logic [31:0] exp_seq;
  } flow_rec_t;

  localparam int unsigned FLOW_W = $bits(flow_rec_t);

  typedef struct packed {
    logic             valid;
    logic             full;
    logic             created;
    logic [IDX_W-1:0] slot;
  } lookup_res_t;

  typedef enum logic [1:0] {
    VERDICT_IN_ORDER  = 2'd0,
    VERDICT_GAP       = 2'd1,
    VERDICT_BACKWARD  = 2'd2,
    VERDICT_UNTRACKED = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } top_state_t;

  typedef enum logic {
    LK_IDLE,
    LK_SCAN
  } lk_state_t;

endpackage

FILE: design/pft_ram.sv
module pft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/pft_lookup.sv
`include "per_flow_sequence_tracker_top_defines.svh"

// Linear search of the learned keys, one entry per cycle, with allocation on a miss while a free entry is left.
module pft_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pft_pkg::key_t       key,
  output pft_pkg::lookup_res_t res
);

  pft_pkg::lk_state_t state, state_next;

  pft_pkg::key_t                 key_q;
  pft_pkg::key_t                 key_rdata;
  logic [pft_pkg::CNT_W-1:0]     used;
  logic [pft_pkg::CNT_W-1:0]     rd_idx;
  logic                          cmp_valid;
  logic [pft_pkg::IDX_W-1:0]     cmp_idx;

  logic issue;
  logic match;
  logic last;
  logic none;
  logic finish;
  logic full_miss;
  logic alloc;

  pft_ram #(
    .WIDTH(pft_pkg::KEY_W),
    .DEPTH(pft_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (alloc),
    .wr_addr(used[pft_pkg::IDX_W-1:0]),
    .wr_data(key_q),
    .rd_en  (issue),
    .rd_addr(rd_idx[pft_pkg::IDX_W-1:0]),
    .rd_data(key_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      pft_pkg::LK_IDLE: begin
        if (start) begin
          state_next = pft_pkg::LK_SCAN;
        end
      end
      pft_pkg::LK_SCAN: begin
        if (finish) begin
          state_next = pft_pkg::LK_IDLE;
        end
      end
      default: state_next = pft_pkg::LK_IDLE;
    endcase
  end

  always_comb begin
    issue     = 1'b0;
    match     = 1'b0;
    last      = 1'b0;
    none      = 1'b0;
    finish    = 1'b0;
    full_miss = 1'b0;
    alloc     = 1'b0;
    case (state)
      pft_pkg::LK_SCAN: begin
        issue     = rd_idx < used;
        match     = cmp_valid && (key_rdata == key_q);
        last      = cmp_valid &&
                    ((pft_pkg::CNT_W'(cmp_idx) + pft_pkg::CNT_W'(1)) == used);
        none      = !cmp_valid && (rd_idx >= used);
        finish    = match || last || none;
        full_miss = finish && !match && (used == pft_pkg::CNT_W'(pft_pkg::TABLE_DEPTH));
        alloc     = finish && !match && !full_miss;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pft_pkg::LK_IDLE;
      used      <= '0;
      cmp_valid <= 1'b0;
      res       <= '0;
    end else begin
      state     <= state_next;
      res.valid <= finish;
      if (state == pft_pkg::LK_IDLE) begin
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= issue && !finish;
      end
      if (finish) begin
        res.full    <= full_miss;
        res.created <= alloc;
        res.slot    <= match ? cmp_idx : used[pft_pkg::IDX_W-1:0];
      end
      if (alloc) begin
        used <= used + pft_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pft_pkg::LK_IDLE) begin
      rd_idx <= '0;
      if (start) begin
        key_q <= key;
      end
    end else begin
      cmp_idx <= rd_idx[pft_pkg::IDX_W-1:0];
      if (issue) begin
        rd_idx <= rd_idx + pft_pkg::CNT_W'(1);
      end
    end
  end

  `PFT_ASSERT_SAME(a_used_bounded, 1'b1, used <= pft_pkg::CNT_W'(pft_pkg::TABLE_DEPTH), "fill count beyond table depth")
  `PFT_ASSERT_SAME(a_full_only_when_full, res.valid && res.full, used == pft_pkg::CNT_W'(pft_pkg::TABLE_DEPTH), "full verdict with free entries")
  `PFT_ASSERT_SAME(a_slot_in_use, res.valid && !res.full, pft_pkg::CNT_W'(res.slot) < used, "result slot not in use")

endmodule

FILE: design/per_flow_sequence_tracker_top.sv
// Per-flow sequence tracker. Each input word is one validated datagram
// (source address, source port, sequence number); each accepted word gives
// exactly one output word with the verdict (in order, forward gap, backward,
// or untracked because the flow table is full), the table slot, a flag for a
// newly learned flow, and the flow's expected sequence and counters after the
// update, together with the global untracked count. Flows are learned in
// arrival order into a table of pft_pkg::TABLE_DEPTH entries and are never
// evicted. The keys sit in one memory that is searched linearly, one entry
// per cycle, so the search grows with the number of learned flows. The
// per-flow expected value and 64-bit counters sit in a second memory that is
// read, updated and written back once per tracked datagram. One datagram is
// handled at a time; a new word is accepted as soon as the previous one has
// left the search and update path, even while its result still waits in the
// output register. The table is ready immediately after reset and needs no
// clearing pass.
`include "per_flow_sequence_tracker_top_defines.svh"

module per_flow_sequence_tracker_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: src_addr[31:0], src_port[47:32], seq_num[79:48].
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0 up: verdict[1:0], flow_slot[7:2], flow_created[8],
  // next_expected[40:9], received_count[104:41], gap_count[168:105],
  // backward_count[232:169], untracked_total[296:233], zero fill [303:297].
  output logic [303:0] m_axis_tdata
);

  pft_pkg::top_state_t state, state_next;

  pft_pkg::key_t        in_key;
  logic                 in_accept;
  logic                 lk_start;
  pft_pkg::lookup_res_t lk_res;
  pft_pkg::lookup_res_t lk_q;
  logic [31:0]          seq_q;

  logic                 flow_rd_en;
  logic                 flow_wr_en;
  logic                 ld_out;
  logic [pft_pkg::FLOW_W-1:0] flow_rdata;
  pft_pkg::flow_rec_t   rec_old;
  pft_pkg::flow_rec_t   rec_new;
  logic                 seq_eq;
  logic                 seq_gt;
  pft_pkg::verdict_t    verdict;

  logic [63:0]          dropped_counter;
  logic [63:0]          dropped_next;

  // Output register.
  pft_pkg::verdict_t          out_verdict;
  logic [pft_pkg::SLOT_W-1:0] out_slot;
  logic                       out_created;
  logic [31:0]                out_expected;
  logic [63:0]                out_recv;
  logic [63:0]                out_gap;
  logic [63:0]                out_back;
  logic [63:0]                out_untracked;

  assign in_key.addr = s_axis_tdata[31:0];
  assign in_key.port = s_axis_tdata[47:32];
  assign s_axis_tready = (state == pft_pkg::ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  pft_lookup u_lookup (
    .clk  (clk),
    .rst  (rst),
    .start(lk_start),
    .key  (in_key),
    .res  (lk_res)
  );

  // Expected value and counters of each flow, updated in place.
  pft_ram #(
    .WIDTH(pft_pkg::FLOW_W),
    .DEPTH(pft_pkg::TABLE_DEPTH)
  ) u_flow_ram (
    .clk    (clk),
    .wr_en  (flow_wr_en),
    .wr_addr(lk_q.slot),
    .wr_data(rec_new),
    .rd_en  (flow_rd_en),
    .rd_addr(lk_res.slot),
    .rd_data(flow_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      pft_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = pft_pkg::ST_LOOK;
        end
      end
      pft_pkg::ST_LOOK: begin
        if (lk_res.valid) begin
          state_next = pft_pkg::ST_UPDATE;
        end
      end
      pft_pkg::ST_UPDATE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = pft_pkg::ST_IDLE;
        end
      end
      default: state_next = pft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lk_start   = 1'b0;
    flow_rd_en = 1'b0;
    ld_out     = 1'b0;
    flow_wr_en = 1'b0;
    case (state)
      pft_pkg::ST_IDLE: begin
        lk_start = in_accept;
      end
      pft_pkg::ST_LOOK: begin
        flow_rd_en = lk_res.valid && !lk_res.full;
      end
      pft_pkg::ST_UPDATE: begin
        ld_out     = !m_axis_tvalid || m_axis_tready;
        flow_wr_en = ld_out && !lk_q.full;
      end
      default: begin
      end
    endcase
  end

  // A freshly claimed entry starts from zero, whatever the memory holds.
  always_comb begin
    rec_old = lk_q.created ? '0 : pft_pkg::flow_rec_t'(flow_rdata);
    seq_eq  = (seq_q == rec_old.exp_seq);
    seq_gt  = (seq_q > rec_old.exp_seq);
    rec_new = rec_old;
    rec_new.recv = rec_old.recv + 64'd1;
    if (seq_eq) begin
      rec_new.exp_seq = seq_q + 32'd1;
      verdict = pft_pkg::VERDICT_IN_ORDER;
    end else if (seq_gt) begin
      rec_new.exp_seq = seq_q + 32'd1;
      rec_new.gap     = rec_old.gap + 64'd1;
      verdict = pft_pkg::VERDICT_GAP;
    end else begin
      rec_new.back = rec_old.back + 64'd1;
      verdict = pft_pkg::VERDICT_BACKWARD;
    end
    dropped_next = dropped_counter + (lk_q.full ? 64'd1 : 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pft_pkg::ST_IDLE;
      dropped_counter <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ld_out) begin
        dropped_counter <= dropped_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      seq_q <= s_axis_tdata[79:48];
    end
    if (lk_res.valid) begin
      lk_q <= lk_res;
    end
    if (ld_out) begin
      out_untracked <= dropped_next;
      if (lk_q.full) begin
        out_verdict  <= pft_pkg::VERDICT_UNTRACKED;
        out_slot     <= '0;
        out_created  <= 1'b0;
        out_expected <= '0;
        out_recv     <= '0;
        out_gap      <= '0;
        out_back     <= '0;
      end else begin
        out_verdict  <= verdict;
        out_slot     <= pft_pkg::SLOT_W'(lk_q.slot);
        out_created  <= lk_q.created;
        out_expected <= rec_new.exp_seq;
        out_recv     <= rec_new.recv;
        out_gap      <= rec_new.gap;
        out_back     <= rec_new.back;
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_untracked, out_back, out_gap, out_recv,
                         out_expected, out_created, out_slot, out_verdict};

  `PFT_ASSERT_SAME(a_lookup_when_waiting, lk_res.valid, state == pft_pkg::ST_LOOK, "lookup result outside lookup phase")
  `PFT_ASSERT_NEXT(a_untracked_counts, ld_out && lk_q.full, m_axis_tdata[296:233] == $past(dropped_counter) + 64'd1, "untracked total not advanced")
  `PFT_ASSERT_NEXT(a_new_flow_first, ld_out && !lk_q.full && lk_q.created, m_axis_tdata[104:41] == 64'd1, "new flow without a single received datagram")

endmodule

FILE: tb/sv/testbench.sv
// Check the per-flow sequence tracker over its stream ports. Datagram words are
// driven on the slave side and every result word is checked against a
// behavioural copy of the flow table that is kept inside this module.
module testbench;

  // One datagram as the sender sees it.
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seq;
  } datagram_t;

  // One result word, field by field. This is a packed struct, so a single
  // equality compares every field at once.
  typedef struct packed {
    pft_pkg::verdict_t verdict;
    logic [5:0]  slot;
    logic        created;
    logic [31:0] next_seq;
    logic [63:0] recv;
    logic [63:0] gaps;
    logic [63:0] back;
    logic [63:0] untracked;
  } flow_report_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [303:0] m_axis_tdata;

  // The testbench's own copy of the flow table. Only entries below
  // flows_learned are ever looked at, which matches the block.
  logic [31:0]  flow_addr [pft_pkg::TABLE_DEPTH];
  logic [15:0]  flow_port [pft_pkg::TABLE_DEPTH];
  logic [31:0]  flow_next [pft_pkg::TABLE_DEPTH];
  logic [63:0]  flow_recv [pft_pkg::TABLE_DEPTH];
  logic [63:0]  flow_gaps [pft_pkg::TABLE_DEPTH];
  logic [63:0]  flow_back [pft_pkg::TABLE_DEPTH];
  int unsigned  flows_learned = 0;
  logic [63:0]  untracked_cnt = '0;

  // Results that have been worked out but have not yet come out of the block.
  flow_report_t reports_due [$];
  int unsigned  mismatches = 0;

  // Handshake pressure. The receiver process counts hold_left and burst_left down.
  bit           idling_on = 1'b1;
  int unsigned  hold_left = 0;
  int unsigned  burst_left = 0;

  per_flow_sequence_tracker_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Look the key up, claim a free entry on a miss, classify the sequence and
  // give back the result word that the block ought to produce.
  function automatic flow_report_t track_datagram(input datagram_t d);
    flow_report_t r;
    int unsigned  idx;
    bit           found;
    r = '0;
    idx = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < flows_learned; i++) begin
      if (!found && flow_addr[i] == d.addr && flow_port[i] == d.port) begin
        idx = i;
        found = 1'b1;
      end
    end
    if (!found && flows_learned >= pft_pkg::TABLE_DEPTH) begin
      // The table is full, so only the global drop count moves.
      untracked_cnt++;
      r.verdict = pft_pkg::VERDICT_UNTRACKED;
    end else begin
      if (!found) begin
        idx = flows_learned;
        flows_learned++;
        flow_addr[idx] = d.addr;
        flow_port[idx] = d.port;
        flow_next[idx] = '0;
        flow_recv[idx] = '0;
        flow_gaps[idx] = '0;
        flow_back[idx] = '0;
        r.created = 1'b1;
      end
      // The comparison is plain unsigned, so the top sequence number wraps
      // the expected value round to zero.
      if (d.seq == flow_next[idx]) begin
        flow_next[idx] = d.seq + 32'd1;
        r.verdict = pft_pkg::VERDICT_IN_ORDER;
      end else if (d.seq > flow_next[idx]) begin
        flow_gaps[idx]++;
        flow_next[idx] = d.seq + 32'd1;
        r.verdict = pft_pkg::VERDICT_GAP;
      end else begin
        flow_back[idx]++;
        r.verdict = pft_pkg::VERDICT_BACKWARD;
      end
      flow_recv[idx]++;
      r.slot = 6'(idx);
      r.next_seq = flow_next[idx];
      r.recv = flow_recv[idx];
      r.gaps = flow_gaps[idx];
      r.back = flow_back[idx];
    end
    r.untracked = untracked_cnt;
    return r;
  endfunction

  // Compare one result word from the block with the oldest expected result.
  function automatic void check_report(input logic [303:0] word);
    flow_report_t got;
    flow_report_t want;
    got.verdict   = pft_pkg::verdict_t'(word[1:0]);
    got.slot      = word[7:2];
    got.created   = word[8];
    got.next_seq  = word[40:9];
    got.recv      = word[104:41];
    got.gaps      = word[168:105];
    got.back      = word[232:169];
    got.untracked = word[296:233];
    if (reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result word with nothing expected: %h", word);
      end
    end else begin
      want = reports_due.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("expected verdict %0d slot %0d new %0d next %h recv %0d gap %0d back %0d drop %0d",
                   want.verdict, want.slot, want.created, want.next_seq, want.recv,
                   want.gaps, want.back, want.untracked);
          $display("actual   verdict %0d slot %0d new %0d next %h recv %0d gap %0d back %0d drop %0d",
                   got.verdict, got.slot, got.created, got.next_seq, got.recv,
                   got.gaps, got.back, got.untracked);
        end
      end
    end
  endfunction

  // Every output word is taken at the rising edge where its handshake completes.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_report(m_axis_tdata);
    end
  end

  // The receiver. A long hold-off that a test asks for wins over everything
  // else. Otherwise ready drops in short random bursts while idling is on.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one datagram, starting at a falling edge and returning at one. Valid
  // is lowered only when a gap comes first, so a run of back-to-back words
  // keeps it high.
  task automatic send_datagram(input datagram_t d);
    int unsigned pause;
    pause = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (pause != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d.seq, d.port, d.addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reports_due.push_back(track_datagram(d));
    @(negedge clk);
  endtask

  // Build a datagram. new_pct is the chance, in percent, of a key that has not
  // been seen before. Other datagrams go to a learned flow. Most of them are in
  // order, and the rest are small forward jumps, random values anywhere in the
  // range, or values below the expected value.
  function automatic datagram_t make_datagram(input int unsigned new_pct);
    datagram_t   d;
    int unsigned s;
    int unsigned pick;
    if (flows_learned == 0 || $urandom_range(0, 99) < new_pct) begin
      d.addr = $urandom;
      d.port = 16'($urandom_range(0, 16'hFFFF));
      d.seq  = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom);
    end else begin
      s = $urandom_range(0, flows_learned - 1);
      d.addr = flow_addr[s];
      d.port = flow_port[s];
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        d.seq = flow_next[s];
      end else if (pick < 80) begin
        d.seq = flow_next[s] + 32'($urandom_range(1, 16));
      end else if (pick < 85) begin
        d.seq = $urandom;
      end else if (flow_next[s] == 32'd0) begin
        d.seq = $urandom;
      end else begin
        d.seq = 32'($urandom_range(0, flow_next[s] - 1));
      end
    end
    return d;
  endfunction

  task automatic wait_for_reports();
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // Directed start. It covers in order, duplicate, small and large jumps, the
  // sequence wrap at the top of the range, all-zero and all-one keys, and two
  // keys that differ only in the port.
  task automatic test_directed();
    send_datagram('{32'h0000_0000, 16'h0000, 32'h0000_0000});
    send_datagram('{32'h0000_0000, 16'h0000, 32'h0000_0000});
    send_datagram('{32'h0000_0000, 16'h0000, 32'h0000_0001});
    send_datagram('{32'h0000_0000, 16'h0000, 32'h0000_000A});
    send_datagram('{32'h0000_0000, 16'h0000, 32'hFFFF_FFFF});
    send_datagram('{32'h0000_0000, 16'h0000, 32'h0000_0000});
    send_datagram('{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_datagram('{32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000});
    send_datagram('{32'h0000_0000, 16'hFFFF, 32'h0000_0000});
    send_datagram('{32'h0000_0000, 16'hFFFF, 32'h0000_0000});
    send_datagram('{32'hFFFF_FFFF, 16'h0000, 32'h0000_0005});
    send_datagram('{32'hAAAA_AAAA, 16'h5555, 32'h5555_5555});
    send_datagram('{32'hAAAA_AAAA, 16'h5555, 32'h5555_5556});
    send_datagram('{32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA});
    send_datagram('{32'h5555_5555, 16'hAAAA, 32'h0000_0003});
  endtask

  // Mostly traffic on known flows, with new flows now and then.
  task automatic test_flow_mix();
    repeat (180) send_datagram(make_datagram(10));
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // output register fills up and the block stops taking input.
  task automatic test_backlog();
    hold_left = 400;
    repeat (24) send_datagram(make_datagram(10));
  endtask

  // The sender goes quiet until every outstanding result has come back.
  task automatic test_drain_pause();
    repeat (10) send_datagram(make_datagram(10));
    s_axis_tvalid <= 1'b0;
    wait_for_reports();
    repeat (10) send_datagram(make_datagram(10));
  endtask

  // Learn flows until the table is full. After that, new keys are dropped as
  // untracked while the learned flows are still followed.
  task automatic test_table_full();
    while (flows_learned < pft_pkg::TABLE_DEPTH) send_datagram(make_datagram(100));
    repeat (80) send_datagram(make_datagram(30));
  endtask

  // Closing stretch at full rate, with no idling on either side.
  task automatic test_quiet_tail();
    idling_on = 1'b0;
    repeat (50) send_datagram(make_datagram(20));
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_flow_mix();
    test_backlog();
    test_drain_pause();
    test_table_full();
    test_quiet_tail();

    s_axis_tvalid <= 1'b0;
    wait_for_reports();
    // Leave room for a stray extra word. The search alone may take a pass over
    // the whole table.
    repeat (pft_pkg::TABLE_DEPTH + 16) @(negedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // A correct run ends long before this limit, even with a full table and every
  // stall, so the limit only catches a hang.
  initial begin
    #2400000;
    $display("testbench: errors");
    $finish;
  end

endmodule
